// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the back end (lcb_back).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define LCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define LCB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/lcb_pkg.sv =====
package lcb_pkg;

  // Default sizes of the block.
  localparam int DEF_MAX_ITEMS   = 64;
  localparam int DEF_MAX_COLUMNS = 8;
  localparam int QUEUE_DEPTH     = 4;

  // Column count after reset.
  localparam logic [3:0] COLUMN_COUNT_RESET = 4'd2;

  // One input item.
  typedef struct packed {
    logic       group_root;
    logic [5:0] child_count;
    logic       last_item;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [5:0] source_index;
    logic [2:0] column;
    logic [5:0] row;
    logic [5:0] new_index;
    logic [6:0] column_height;
    logic [6:0] tallest_column;
    logic       last_result;
  } out_item_t;

  // A finished block as handed from the front end to the back end.
  // A size of zero carries only the end-of-list mark.
  typedef struct packed {
    logic [5:0] start;
    logic [6:0] size;
    logic       last;
  } blk_rec_t;

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SETUP,
    ST_A_RD,
    ST_A_CHK,
    ST_A_MIN,
    ST_T_SCAN,
    ST_E_RD,
    ST_E_CHK,
    ST_E_OUT
  } back_state_t;

endpackage

// ===== rtl/lcb_queue.sv =====
module lcb_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lcb_pkg::blk_rec_t push_data,
  output logic              full,
  input  logic              pop,
  output lcb_pkg::blk_rec_t pop_data,
  output logic              empty
);
  import lcb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  blk_rec_t        slot_r [DEPTH];
  logic [PW-1:0]   head_r, head_nxt;
  logic [PW-1:0]   tail_r, tail_nxt;
  logic [NW-1:0]   count_r, count_nxt;

  assign full     = (count_r == NW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[head_r];

  // Pointer and fill count update.
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (push) begin
      tail_nxt = (tail_r == PW'(DEPTH - 1)) ? '0 : PW'(tail_r + 1'b1);
    end
    if (pop) begin
      head_nxt = (head_r == PW'(DEPTH - 1)) ? '0 : PW'(head_r + 1'b1);
    end
    if (push && !pop) begin
      count_nxt = NW'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = NW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[tail_r] <= push_data;
    end
  end

endmodule

// ===== rtl/lcb_front.sv =====
module lcb_front #(
  parameter int MAX_ITEMS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lcb_pkg::in_item_t in_data,
  output logic              q_push,
  output lcb_pkg::blk_rec_t q_data,
  input  logic              q_full
);
  import lcb_pkg::*;

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic [CW-1:0] item_cnt_r, item_cnt_nxt;
  logic [5:0]    pend_r, pend_nxt;
  logic [IW-1:0] cur_start_r, cur_start_nxt;
  logic [CW-1:0] cur_size_r, cur_size_nxt;
  logic          accept;
  logic          room;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign room     = (item_cnt_r < CW'(MAX_ITEMS));

  // Group items into blocks; a block is pushed once it is complete,
  // or clipped when the list ends.
  always_comb begin
    item_cnt_nxt  = item_cnt_r;
    pend_nxt      = pend_r;
    cur_start_nxt = cur_start_r;
    cur_size_nxt  = cur_size_r;
    q_push        = 1'b0;
    q_data.start  = 6'(cur_start_r);
    q_data.size   = 7'(cur_size_r);
    q_data.last   = in_data.last_item;
    if (accept) begin
      if (room) begin
        if (pend_r != '0) begin
          // A child extends the open block.
          cur_size_nxt = CW'(cur_size_r + 1'b1);
          pend_nxt     = pend_r - 6'd1;
          q_data.size  = 7'(cur_size_nxt);
          q_push       = (pend_r == 6'd1) || in_data.last_item;
        end else begin
          // This item opens a new block.
          cur_start_nxt = IW'(item_cnt_r);
          cur_size_nxt  = CW'(1);
          q_data.start  = 6'(item_cnt_r);
          q_data.size   = 7'd1;
          if (in_data.group_root && (in_data.child_count != '0) && !in_data.last_item) begin
            pend_nxt = in_data.child_count;
          end else begin
            q_push = 1'b1;
          end
        end
        item_cnt_nxt = CW'(item_cnt_r + 1'b1);
      end else if (in_data.last_item) begin
        // The list is full: flush an open block or just mark the end.
        q_push      = 1'b1;
        q_data.size = (pend_r != '0) ? 7'(cur_size_r) : 7'd0;
      end
      if (in_data.last_item) begin
        item_cnt_nxt = '0;
        pend_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_cnt_r <= '0;
      pend_r     <= '0;
    end else begin
      item_cnt_r <= item_cnt_nxt;
      pend_r     <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_start_r <= cur_start_nxt;
    cur_size_r  <= cur_size_nxt;
  end

endmodule

// ===== rtl/lcb_back.sv =====
module lcb_back #(
  parameter int MAX_ITEMS   = 64,
  parameter int MAX_COLUMNS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [3:0]         column_count,
  input  lcb_pkg::blk_rec_t  q_data,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output lcb_pkg::out_item_t out_data
);
  import lcb_pkg::*;
  `include "assert_macros.svh"

  localparam int IW   = $clog2(MAX_ITEMS);
  localparam int CW   = $clog2(MAX_ITEMS + 1);
  localparam int COLW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int NCW  = $clog2(MAX_COLUMNS + 1);

  back_state_t   state_r, state_nxt;
  logic [CW-1:0] bt_r, bt_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic [CW-1:0] max_r, max_nxt;
  logic [CW-1:0] s_r, s_nxt;
  logic [IW-1:0] b_r, b_nxt;
  logic [NCW-1:0] c_r, c_nxt;
  logic [COLW-1:0] best_r, best_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic [CW-1:0] emit_r, emit_nxt;
  logic [CW-1:0] tall_r, tall_nxt;
  logic [CW-1:0] fill_r [MAX_COLUMNS];
  logic [CW-1:0] fill_nxt [MAX_COLUMNS];

  // Block store.
  logic [IW-1:0]   start_mem [MAX_ITEMS];
  logic [CW-1:0]   size_mem  [MAX_ITEMS];
  logic [COLW-1:0] col_mem   [MAX_ITEMS];
  logic [IW-1:0]   rd_start_r;
  logic [CW-1:0]   rd_size_r;
  logic [COLW-1:0] rd_col_r;
  logic            ld_we;
  logic            col_we;

  logic [NCW-1:0] ncols;
  logic           blk_last, col_last, min_done, hit_a, hit_e, j_end, out_fire;
  logic [COLW-1:0] c_idx;

  // Column count in use: zero acts as one, large values saturate.
  always_comb begin
    if (column_count == '0) begin
      ncols = NCW'(1);
    end else if (32'(column_count) > MAX_COLUMNS) begin
      ncols = NCW'(MAX_COLUMNS);
    end else begin
      ncols = NCW'(column_count);
    end
  end

  assign c_idx    = c_r[COLW-1:0];
  assign q_pop    = (state_r == ST_LOAD) && !q_empty;
  assign ld_we    = q_pop && (q_data.size != '0);
  assign col_we   = (state_r == ST_A_MIN) && min_done;
  assign blk_last = (b_r == IW'(bt_r - 1'b1));
  assign col_last = (c_r == NCW'(ncols - 1'b1));
  assign min_done = (c_r >= ncols);
  assign hit_a    = (rd_size_r == s_r);
  assign hit_e    = (rd_col_r == c_idx);
  assign j_end    = (CW'(j_r + 1'b1) == rd_size_r);
  assign out_fire = out_valid && !out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (q_pop && q_data.last) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        state_nxt = (bt_r == '0) ? ST_LOAD : ST_A_RD;
      end
      ST_A_RD: begin
        state_nxt = ST_A_CHK;
      end
      ST_A_CHK: begin
        if (hit_a) begin
          state_nxt = ST_A_MIN;
        end else begin
          state_nxt = (blk_last && (s_r == CW'(1))) ? ST_T_SCAN : ST_A_RD;
        end
      end
      ST_A_MIN: begin
        if (min_done) begin
          state_nxt = (blk_last && (s_r == CW'(1))) ? ST_T_SCAN : ST_A_RD;
        end
      end
      ST_T_SCAN: begin
        if (min_done) state_nxt = ST_E_RD;
      end
      ST_E_RD: begin
        state_nxt = ST_E_CHK;
      end
      ST_E_CHK: begin
        if (hit_e) begin
          state_nxt = ST_E_OUT;
        end else begin
          state_nxt = (blk_last && col_last) ? ST_LOAD : ST_E_RD;
        end
      end
      ST_E_OUT: begin
        if (out_fire && j_end) begin
          state_nxt = (blk_last && col_last) ? ST_LOAD : ST_E_RD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Counters, column fills and sort/assign/emit bookkeeping.
  always_comb begin
    bt_nxt    = bt_r;
    total_nxt = total_r;
    max_nxt   = max_r;
    s_nxt     = s_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    best_nxt  = best_r;
    j_nxt     = j_r;
    row_nxt   = row_r;
    emit_nxt  = emit_r;
    tall_nxt  = tall_r;
    fill_nxt  = fill_r;
    unique case (state_r)
      ST_LOAD: begin
        if (ld_we) begin
          bt_nxt    = CW'(bt_r + 1'b1);
          total_nxt = CW'(total_r + CW'(q_data.size));
          if (CW'(q_data.size) > max_r) max_nxt = CW'(q_data.size);
        end
      end
      ST_SETUP: begin
        // Sizes are visited from the largest down, blocks in list order.
        s_nxt = max_r;
        b_nxt = '0;
        for (int k = 0; k < MAX_COLUMNS; k++) fill_nxt[k] = '0;
      end
      ST_A_RD: begin
      end
      ST_A_CHK: begin
        if (hit_a) begin
          c_nxt    = NCW'(1);
          best_nxt = '0;
        end else if (blk_last) begin
          b_nxt = '0;
          s_nxt = CW'(s_r - 1'b1);
          c_nxt = '0;
          tall_nxt = '0;
        end else begin
          b_nxt = IW'(b_r + 1'b1);
        end
      end
      ST_A_MIN: begin
        // Search the shortest column, lowest index on ties.
        if (!min_done) begin
          if (fill_r[c_idx] < fill_r[best_r]) best_nxt = c_idx;
          c_nxt = NCW'(c_r + 1'b1);
        end else begin
          fill_nxt[best_r] = CW'(fill_r[best_r] + s_r);
          if (blk_last) begin
            b_nxt    = '0;
            s_nxt    = CW'(s_r - 1'b1);
            c_nxt    = '0;
            tall_nxt = '0;
          end else begin
            b_nxt = IW'(b_r + 1'b1);
          end
        end
      end
      ST_T_SCAN: begin
        // Tallest column, then start the emit pass.
        if (!min_done) begin
          if (fill_r[c_idx] > tall_r) tall_nxt = fill_r[c_idx];
          c_nxt = NCW'(c_r + 1'b1);
        end else begin
          c_nxt    = '0;
          b_nxt    = '0;
          row_nxt  = '0;
          emit_nxt = '0;
        end
      end
      ST_E_RD: begin
      end
      ST_E_CHK: begin
        if (hit_e) begin
          j_nxt = '0;
        end else if (blk_last) begin
          b_nxt   = '0;
          row_nxt = '0;
          c_nxt   = NCW'(c_r + 1'b1);
        end else begin
          b_nxt = IW'(b_r + 1'b1);
        end
      end
      ST_E_OUT: begin
        if (out_fire) begin
          j_nxt    = CW'(j_r + 1'b1);
          row_nxt  = CW'(row_r + 1'b1);
          emit_nxt = CW'(emit_r + 1'b1);
          if (j_end) begin
            if (blk_last) begin
              b_nxt   = '0;
              row_nxt = '0;
              c_nxt   = NCW'(c_r + 1'b1);
            end else begin
              b_nxt = IW'(b_r + 1'b1);
            end
          end
        end
      end
      default: begin
      end
    endcase
    // The list is emptied once the layout has been delivered.
    if ((state_r != ST_LOAD) && (state_nxt == ST_LOAD)) begin
      bt_nxt    = '0;
      total_nxt = '0;
      max_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      bt_r    <= '0;
      total_r <= '0;
      max_r   <= '0;
      for (int k = 0; k < MAX_COLUMNS; k++) fill_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      bt_r    <= bt_nxt;
      total_r <= total_nxt;
      max_r   <= max_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r    <= s_nxt;
    b_r    <= b_nxt;
    c_r    <= c_nxt;
    best_r <= best_nxt;
    j_r    <= j_nxt;
    row_r  <= row_nxt;
    emit_r <= emit_nxt;
    tall_r <= tall_nxt;
  end

  // Block store writes and registered reads at the current block.
  always_ff @(posedge clk) begin
    if (ld_we) begin
      start_mem[bt_r[IW-1:0]] <= IW'(q_data.start);
      size_mem[bt_r[IW-1:0]]  <= CW'(q_data.size);
    end
    if (col_we) begin
      col_mem[b_r] <= best_r;
    end
    rd_start_r <= start_mem[b_r];
    rd_size_r  <= size_mem[b_r];
    rd_col_r   <= col_mem[b_r];
  end

  // Result item, held while the receiver stalls.
  assign out_valid               = (state_r == ST_E_OUT);
  assign out_data.source_index   = 6'(CW'(rd_start_r) + j_r);
  assign out_data.column         = 3'(c_r);
  assign out_data.row            = 6'(row_r);
  assign out_data.new_index      = 6'(emit_r);
  assign out_data.column_height  = 7'(fill_r[c_idx]);
  assign out_data.tallest_column = 7'(tall_r);
  assign out_data.last_result    = (CW'(emit_r + 1'b1) == total_r);

  `LCB_ASSERT(a_bt_bound, bt_r <= CW'(MAX_ITEMS), "block count above list capacity")
  `LCB_ASSERT(a_best_range, (state_r != ST_A_MIN) || (NCW'(best_r) < ncols), "best column out of range")
  `LCB_ASSERT(a_emit_bound, (state_r != ST_E_OUT) || (emit_r < total_r), "more results than items")
  `LCB_ASSERT_NEXT(a_setup_clear, state_r == ST_SETUP, fill_r[0] == '0, "column fill not cleared")

endmodule

// ===== rtl/lpt_column_balancer.sv =====
// Items load at one per cycle while the block queue is not full; a finished block is queued
// at the edge accepting its last item. After the last item, assign walks sizes from the largest
// down through the single block-store read port, with a serial shortest-column search per block
// placed; the tallest column scan follows. Emit reads each block per column scanned and sends
// its result items, pausing while the receiver stalls. Synchronous active-low reset empties the
// list, clears column heights and sets two columns; the block store itself is not cleared.
module lpt_column_balancer #(
  parameter int MAX_ITEMS   = lcb_pkg::DEF_MAX_ITEMS,
  parameter int MAX_COLUMNS = lcb_pkg::DEF_MAX_COLUMNS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lcb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lcb_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_data
);
  import lcb_pkg::*;

  logic [3:0] column_count_r;
  logic       q_push, q_pop, q_full, q_empty;
  blk_rec_t   q_wdata, q_rdata;

  // Column count register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= COLUMN_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      column_count_r <= cfg_data;
    end
  end

  lcb_front #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_full   (q_full)
  );

  lcb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  lcb_back #(
    .MAX_ITEMS   (MAX_ITEMS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .column_count (column_count_r),
    .q_data       (q_rdata),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule

// ===== sim/lpt_column_balancer_tb.sv =====
`timescale 1ns / 100ps

module lpt_column_balancer_tb;
  import lcb_pkg::*;

  localparam int LIST_MAX = 64;
  localparam int COL_MAX  = 8;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [3:0] cfg_data = '0;

  lpt_column_balancer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the balancer state.
  logic [3:0] col_setting;
  int unsigned loaded_items;
  int unsigned blk_start [LIST_MAX];
  int unsigned blk_size  [LIST_MAX];
  int unsigned blk_col   [LIST_MAX];
  int unsigned blk_count;
  int unsigned kids_left;
  int unsigned col_height [COL_MAX];

  out_item_t placed_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int mismatches = 0;
  int items_sent = 0;

  // Clock generation.
  initial begin
    forever #6 clk = ~clk;
  end

  // Run limit.
  initial begin
    #60ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Lay out the loaded list and queue one placement per stored item.
  function automatic void place_blocks();
    int unsigned order [LIST_MAX];
    int unsigned cols, i, j, c, b, best, tallest, total, emitted, row, cur;
    out_item_t r;
    cols = (col_setting == 0) ? 1 : ((col_setting > COL_MAX) ? COL_MAX : col_setting);
    // Stable sort, largest block first.
    for (i = 0; i < blk_count; i++) begin
      cur = i;
      j = i;
      while (j > 0 && blk_size[order[j-1]] < blk_size[cur]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    for (c = 0; c < COL_MAX; c++) col_height[c] = 0;
    // Each block goes to the currently shortest column.
    for (i = 0; i < blk_count; i++) begin
      b = order[i];
      best = 0;
      for (c = 1; c < cols; c++)
        if (col_height[c] < col_height[best]) best = c;
      blk_col[b] = best;
      col_height[best] += blk_size[b];
    end
    tallest = 0;
    total = 0;
    for (c = 0; c < cols; c++) begin
      if (col_height[c] > tallest) tallest = col_height[c];
      total += col_height[c];
    end
    emitted = 0;
    for (c = 0; c < cols; c++) begin
      row = 0;
      for (b = 0; b < blk_count; b++) begin
        if (blk_col[b] == c) begin
          for (j = 0; j < blk_size[b] && emitted < LIST_MAX; j++) begin
            r.source_index   = 6'(blk_start[b] + j);
            r.column         = 3'(c);
            r.row            = 6'(row);
            r.new_index      = 6'(emitted);
            r.column_height  = 7'(col_height[c]);
            r.tallest_column = 7'(tallest);
            r.last_result    = (emitted + 1 == total);
            placed_q = {placed_q, r};
            row++;
            emitted++;
          end
        end
      end
    end
  endfunction

  // Update the shadow state with one accepted item.
  function automatic void load_item(in_item_t it);
    if (loaded_items < LIST_MAX) begin
      if (kids_left > 0 && blk_count > 0) begin
        blk_size[blk_count-1]++;
        kids_left--;
      end else if (blk_count < LIST_MAX) begin
        blk_start[blk_count] = loaded_items;
        blk_size[blk_count] = 1;
        blk_count++;
        kids_left = (it.group_root && it.child_count != 0) ? it.child_count : 0;
      end
      loaded_items++;
    end
    if (it.last_item) begin
      place_blocks();
      loaded_items = 0;
      blk_count = 0;
      kids_left = 0;
    end
  endfunction

  // Offer one item, with random idle cycles ahead of it.
  task automatic send_item(input logic root, input logic [5:0] kids, input logic last);
    in_item_t it;
    it.group_root = root;
    it.child_count = kids;
    it.last_item = last;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    load_item(it);
    items_sent++;
  endtask

  // Send one random list of the given length.
  task automatic send_list(input int len);
    logic root;
    logic [5:0] kids;
    for (int k = 0; k < len; k++) begin
      root = ($urandom_range(2) == 0);
      case ($urandom_range(3))
        0: kids = 6'($urandom_range(63));
        default: kids = 6'($urandom_range(4));
      endcase
      send_item(root, kids, k == len - 1);
    end
  endtask

  // Mostly short lists, a few long ones and a few that overflow.
  function automatic int pick_length();
    int r;
    r = $urandom_range(19);
    if (r == 0) return $urandom_range(70, 40);
    if (r < 3) return $urandom_range(30, 13);
    return $urandom_range(12, 1);
  endfunction

  // Wait until every placement has come out and the block has gone quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (placed_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_columns(input logic [3:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    col_setting = value;
  endtask

  // Receiver stall generation, with an occasional long hold-off.
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left <= 2000;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare each accepted placement with the oldest expected one.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (placed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %p", out_data);
      end else begin
        want = placed_q.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  task automatic test_directed();
    // Single item list, then a root that runs past the end.
    send_item(1'b0, 6'd0, 1'b1);
    send_item(1'b1, 6'd63, 1'b0);
    send_item(1'b0, 6'd63, 1'b0);
    send_item(1'b1, 6'd5, 1'b1);
    // A root without children, and ignored child counts on plain items.
    send_item(1'b1, 6'd0, 1'b0);
    send_item(1'b0, 6'd42, 1'b0);
    // Equal-size blocks keep their order.
    send_item(1'b1, 6'd1, 1'b0);
    send_item(1'b1, 6'd1, 1'b0);
    send_item(1'b1, 6'd1, 1'b0);
    send_item(1'b0, 6'd21, 1'b0);
    send_item(1'b1, 6'd2, 1'b0);
    send_item(1'b0, 6'd0, 1'b0);
    send_item(1'b0, 6'd0, 1'b1);
    // Overflow: the last item beyond the list still starts the layout.
    for (int k = 0; k < 66; k++) send_item(1'b0, 6'd0, k == 65);
    drain();
  endtask

  task automatic test_column_settings();
    logic [3:0] settings [8] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd9, 4'd3, 4'd5, 4'd2};
    foreach (settings[s]) begin
      write_columns(settings[s]);
      send_item(1'b1, 6'd3, 1'b0);
      send_list(pick_length());
    end
  endtask

  task automatic test_random();
    int phase_items;
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      write_columns(4'($urandom_range(15)));
      phase_items = items_sent;
      while (items_sent - phase_items < 20) send_list(pick_length());
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_columns(4'd4);
    hold_requests++;
    send_list(64);
    send_list(40);
    send_list(30);
  endtask

  initial begin
    col_setting = COLUMN_COUNT_RESET;
    loaded_items = 0;
    blk_count = 0;
    kids_left = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_column_settings();
    test_random();
    test_backpressure();
    drain();
    if (mismatches == 0 && placed_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lcb_pkg.sv
rtl/lcb_queue.sv
rtl/lcb_front.sv
rtl/lcb_back.sv
rtl/lpt_column_balancer.sv
sim/lpt_column_balancer_tb.sv
